// ===== rtl/pplook_pkg.sv =====
// ----------------------------------------------------------------------------
// pplook_pkg
// Shared widths, codes and controller/datapath interface types for the
// pure pursuit lookahead search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pplook_pkg;

  // path store
  localparam int PATH_DEPTH = 256;
  localparam int ADDR_W     = $clog2(PATH_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  // field widths
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;
  localparam int COORD_W  = 24;
  localparam int SPD_W    = 16;
  localparam int DIST_W   = 20;
  localparam int INDEX_W  = 8;
  localparam int R2_W     = 2 * DIST_W;
  localparam int WP_W     = 2 * COORD_W + SPD_W;

  // stream packing
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_FIELD_W = INDEX_W + SPD_W + 1 + 2 * COORD_W + INDEX_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // arithmetic widths
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MUL_W   = DIFF_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int A_W     = 50;
  localparam int H_W     = 51;
  localparam int WOP_W   = 49;
  localparam int WLO_W   = 25;
  localparam int WHI_W   = WOP_W - WLO_W;
  localparam int WIDE_W  = 2 * WOP_W;
  localparam int RAD_W   = 100;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int N_W     = 52;
  localparam int DV_W    = 51;
  localparam int Q_W     = 16;
  localparam int T_W     = Q_W + 1;

  // iteration counts
  localparam int WM_STEPS  = 4;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int DIV_STEPS = Q_W;
  localparam int ITER_W    = 6;
  localparam int STEP_W    = 3;

  // register reset
  localparam int LA_RESET = 960;
  localparam logic [R2_W-1:0] R2_RESET = R2_W'(LA_RESET * LA_RESET);

  // input modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_APPEND,
    OP_CL_DIFF,
    OP_M_DXDX,
    OP_M_DYDY,
    OP_CL_CMP,
    OP_SG_P1,
    OP_SG_P2,
    OP_M_FXDX,
    OP_M_FYDY,
    OP_M_FXFX,
    OP_M_FYFY,
    OP_C_FIN,
    OP_WL_HH,
    OP_WL_AC,
    OP_WSTEP,
    OP_W_HH,
    OP_DISC,
    OP_SQ_STEP,
    OP_NCALC,
    OP_NSEL,
    OP_DIV_STEP,
    OP_M_TX,
    OP_M_TY,
    OP_HIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ADDR_W-1:0] addr;
    logic [STEP_W-1:0] step;
    logic              first;
    logic              seed;
  } dp_cmd_t;

  typedef struct packed {
    logic dd_less;
    logic a_zero;
    logic c_neg;
    logic ac_gt_hh;
    logic ok1;
    logic ok2;
    logic spd_zero;
  } dp_stat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              query;
    logic              found;
    logic [ADDR_W-1:0] best;
    logic [ADDR_W-1:0] last_index;
  } ctl_res_t;

endpackage

`default_nettype wire

// ===== rtl/pplook_ram.sv =====
// ----------------------------------------------------------------------------
// pplook_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pplook_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/pplook_dp.sv =====
// ----------------------------------------------------------------------------
// pplook_dp
// Datapath: waypoint store, shared 26x26 multiplier, wide product
// accumulator, bit-serial square root and Q16 divider, lookahead point.
// ----------------------------------------------------------------------------
`default_nettype none

module pplook_dp
  import pplook_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic signed [SPD_W-1:0]   in_spd,
  input  logic                      cfg_we,
  input  logic [DIST_W-1:0]         cfg_data,
  output logic signed [COORD_W-1:0] last_x,
  output logic signed [COORD_W-1:0] last_y,
  output logic signed [SPD_W-1:0]   best_spd
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (Q_W - 1);
  localparam logic [T_W-1:0]           T_ONE    = T_W'(1) << Q_W;

  logic [R2_W-1:0] r2;
  logic signed [COORD_W-1:0] rx, ry, p1x, p1y, nx;
  logic signed [SPD_W-1:0] wr_spd, cur_spd;
  logic signed [DIFF_W-1:0] dx, dy, fx, fy;
  logic signed [PROD_W-1:0] prod;
  logic [A_W-1:0] a, bd;
  logic signed [H_W-1:0] h, c;
  logic [WOP_W-1:0] wa, wb;
  logic [WIDE_W-1:0] acc, hh;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem_s;
  logic [ROOT_W-1:0] root;
  logic signed [N_W-1:0] n2, n1;
  logic [DV_W-1:0] dvr;
  logic [Q_W-1:0] q;
  logic n_eq_a;

  logic [WP_W-1:0] rd, wdata;
  logic ram_we;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic signed [SPD_W-1:0] rd_spd;

  // waypoint store
  assign ram_we = (cmd.op == OP_APPEND);
  assign wdata  = {wr_spd, ry, rx};
  assign rd_x   = $signed(rd[COORD_W-1:0]);
  assign rd_y   = $signed(rd[2*COORD_W-1:COORD_W]);
  assign rd_spd = $signed(rd[WP_W-1:2*COORD_W]);

  pplook_ram #(.WIDTH(WP_W), .DEPTH(PATH_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (cmd.addr),
    .wdata (wdata),
    .rdata (rd)
  );

  // derived values
  logic signed [MUL_W-1:0] ma, mb;
  logic [WIDE_W-1:0] prod_u;
  logic [A_W-1:0] dd;
  logic [WOP_W-1:0] abs_h, abs_c;
  logic signed [N_W-1:0] a_s, nsel;
  logic [T_W-1:0] t;
  logic signed [PROD_W-1:0] rnd_sum, rnd_sh;
  logic [REM_W-1:0] rem_sh, trial;
  logic [DV_W-1:0] dv_sh;

  assign prod_u  = WIDE_W'($unsigned(prod));
  assign dd      = a + A_W'($unsigned(prod));
  assign abs_h   = WOP_W'(h[H_W-1] ? -h : h);
  assign abs_c   = WOP_W'(c[H_W-1] ? -c : c);
  assign a_s     = $signed(N_W'(a));
  assign nsel    = stat.ok2 ? n2 : n1;
  assign t       = n_eq_a ? T_ONE : T_W'(q);
  assign rnd_sum = prod + RND_HALF;
  assign rnd_sh  = rnd_sum >>> Q_W;
  assign rem_sh  = {rem_s[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial   = REM_W'({root, 2'b01});
  assign dv_sh   = {dvr[DV_W-2:0], 1'b0};

  // status to the controller
  assign stat.dd_less  = (dd < bd);
  assign stat.a_zero   = (a == '0);
  assign stat.c_neg    = c[H_W-1];
  assign stat.ac_gt_hh = (acc > hh);
  assign stat.ok1      = !n1[N_W-1] && (n1 <= a_s);
  assign stat.ok2      = !n2[N_W-1] && (n2 <= a_s);
  assign stat.spd_zero = (best_spd == '0);

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_M_DXDX: begin ma = MUL_W'(dx); mb = MUL_W'(dx); end
      OP_M_DYDY: begin ma = MUL_W'(dy); mb = MUL_W'(dy); end
      OP_M_FXDX: begin ma = MUL_W'(fx); mb = MUL_W'(dx); end
      OP_M_FYDY: begin ma = MUL_W'(fy); mb = MUL_W'(dy); end
      OP_M_FXFX: begin ma = MUL_W'(fx); mb = MUL_W'(fx); end
      OP_M_FYFY: begin ma = MUL_W'(fy); mb = MUL_W'(fy); end
      OP_M_TX:   begin ma = MUL_W'(dx); mb = MUL_W'($signed({1'b0, t})); end
      OP_M_TY:   begin ma = MUL_W'(dy); mb = MUL_W'($signed({1'b0, t})); end
      OP_WSTEP: begin
        case (cmd.step)
          3'd0: begin
            ma = MUL_W'($signed({1'b0, wa[WLO_W-1:0]}));
            mb = MUL_W'($signed({1'b0, wb[WLO_W-1:0]}));
          end
          3'd1: begin
            ma = MUL_W'($signed({1'b0, wa[WLO_W-1:0]}));
            mb = MUL_W'($signed({1'b0, wb[WOP_W-1:WLO_W]}));
          end
          3'd2: begin
            ma = MUL_W'($signed({1'b0, wa[WOP_W-1:WLO_W]}));
            mb = MUL_W'($signed({1'b0, wb[WLO_W-1:0]}));
          end
          3'd3: begin
            ma = MUL_W'($signed({1'b0, wa[WOP_W-1:WLO_W]}));
            mb = MUL_W'($signed({1'b0, wb[WOP_W-1:WLO_W]}));
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // lookahead point and circle radius squared
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
      r2     <= R2_RESET;
    end else begin
      if (cfg_we) begin
        r2 <= R2_W'(cfg_data) * R2_W'(cfg_data);
      end
      if (cmd.op == OP_APPEND && cmd.seed) begin
        last_x <= rx;
        last_y <= ry;
      end else if (cmd.op == OP_HIT) begin
        last_x <= nx;
        last_y <= p1y + COORD_W'(rnd_sh);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        rx     <= in_x;
        ry     <= in_y;
        wr_spd <= in_spd;
      end
      OP_CL_DIFF: begin
        dx      <= DIFF_W'(rx) - DIFF_W'(rd_x);
        dy      <= DIFF_W'(ry) - DIFF_W'(rd_y);
        cur_spd <= rd_spd;
      end
      OP_M_DYDY: a <= A_W'($unsigned(prod));
      OP_CL_CMP: begin
        if (cmd.first || stat.dd_less) begin
          bd       <= dd;
          best_spd <= cur_spd;
        end
      end
      OP_SG_P1: begin
        p1x <= rd_x;
        p1y <= rd_y;
      end
      OP_SG_P2: begin
        dx <= DIFF_W'(rd_x) - DIFF_W'(p1x);
        dy <= DIFF_W'(rd_y) - DIFF_W'(p1y);
        fx <= DIFF_W'(p1x) - DIFF_W'(rx);
        fy <= DIFF_W'(p1y) - DIFF_W'(ry);
      end
      OP_M_FXDX: a <= dd;
      OP_M_FYDY: h <= H_W'(prod);
      OP_M_FXFX: h <= h + H_W'(prod);
      OP_M_FYFY: c <= H_W'(prod) - $signed(H_W'(r2));
      OP_C_FIN:  c <= c + H_W'(prod);
      OP_WL_HH: begin
        wa  <= abs_h;
        wb  <= abs_h;
        acc <= '0;
      end
      OP_WL_AC: begin
        wa  <= WOP_W'(a);
        wb  <= abs_c;
        acc <= '0;
      end
      OP_WSTEP: begin
        // fold in the partial product issued on the previous step
        case (cmd.step)
          3'd1:       acc <= acc + prod_u;
          3'd2, 3'd3: acc <= acc + (prod_u << WLO_W);
          3'd4:       acc <= acc + (prod_u << (2 * WLO_W));
          default: ;
        endcase
      end
      OP_W_HH: hh <= acc;
      OP_DISC: begin
        rad   <= stat.c_neg ? RAD_W'(hh) + RAD_W'(acc) : RAD_W'(hh) - RAD_W'(acc);
        rem_s <= '0;
        root  <= '0;
      end
      OP_SQ_STEP: begin
        // one root bit per step, restoring
        rad <= rad << 2;
        if (rem_sh >= trial) begin
          rem_s <= rem_sh - trial;
          root  <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem_s <= rem_sh;
          root  <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      OP_NCALC: begin
        n2 <= N_W'($signed({1'b0, root})) - N_W'(h);
        n1 <= -N_W'(h) - N_W'($signed({1'b0, root}));
      end
      OP_NSEL: begin
        dvr    <= DV_W'($unsigned(nsel));
        n_eq_a <= (nsel == a_s);
        q      <= '0;
      end
      OP_DIV_STEP: begin
        if (dv_sh >= DV_W'(a)) begin
          dvr <= dv_sh - DV_W'(a);
          q   <= {q[Q_W-2:0], 1'b1};
        end else begin
          dvr <= dv_sh;
          q   <= {q[Q_W-2:0], 1'b0};
        end
      end
      OP_M_TY: nx <= p1x + COORD_W'(rnd_sh);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pplook_ctrl.sv =====
// ----------------------------------------------------------------------------
// pplook_ctrl
// Controller: accepts items, sequences the nearest-waypoint scan and the
// segment intersection search, and hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pplook_ctrl
  import pplook_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_load,
  output dp_cmd_t           cmd,
  input  dp_stat_t          stat,
  output ctl_res_t          res
);

  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_APPEND   = 6'd1;
  localparam logic [5:0] S_OUT      = 6'd2;
  localparam logic [5:0] S_CL_RD    = 6'd3;
  localparam logic [5:0] S_CL_DIFF  = 6'd4;
  localparam logic [5:0] S_CL_MX    = 6'd5;
  localparam logic [5:0] S_CL_MY    = 6'd6;
  localparam logic [5:0] S_CL_CMP   = 6'd7;
  localparam logic [5:0] S_CL_END   = 6'd8;
  localparam logic [5:0] S_SG_RD1   = 6'd9;
  localparam logic [5:0] S_SG_RD2   = 6'd10;
  localparam logic [5:0] S_SG_P2    = 6'd11;
  localparam logic [5:0] S_SG_MDX   = 6'd12;
  localparam logic [5:0] S_SG_MDY   = 6'd13;
  localparam logic [5:0] S_SG_MFXDX = 6'd14;
  localparam logic [5:0] S_SG_MFYDY = 6'd15;
  localparam logic [5:0] S_SG_MFXFX = 6'd16;
  localparam logic [5:0] S_SG_MFYFY = 6'd17;
  localparam logic [5:0] S_SG_CFIN  = 6'd18;
  localparam logic [5:0] S_SG_WLH   = 6'd19;
  localparam logic [5:0] S_SG_WSH   = 6'd20;
  localparam logic [5:0] S_SG_WHH   = 6'd21;
  localparam logic [5:0] S_SG_WLA   = 6'd22;
  localparam logic [5:0] S_SG_WSA   = 6'd23;
  localparam logic [5:0] S_SG_DISC  = 6'd24;
  localparam logic [5:0] S_SG_SQ    = 6'd25;
  localparam logic [5:0] S_SG_NCALC = 6'd26;
  localparam logic [5:0] S_SG_NSEL  = 6'd27;
  localparam logic [5:0] S_SG_DIV   = 6'd28;
  localparam logic [5:0] S_SG_MTX   = 6'd29;
  localparam logic [5:0] S_SG_MTY   = 6'd30;
  localparam logic [5:0] S_SG_HIT   = 6'd31;
  localparam logic [5:0] S_SG_NEXT  = 6'd32;

  logic [5:0] state, state_next;
  logic [CNT_W-1:0] count, idx;
  logic [ITER_W-1:0] iter;
  logic [ADDR_W-1:0] start;
  logic [CNT_W:0] idx_p1, idx_p2, start_p1;
  logic accept, full;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(PATH_DEPTH));
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);
  assign start    = (res.best > res.last_index) ? res.best : res.last_index;
  assign idx_p1   = {1'b0, idx} + 1'b1;
  assign idx_p2   = {1'b0, idx} + 2'd2;
  assign start_p1 = (CNT_W + 1)'(start) + 1'b1;

  // datapath command
  always_comb begin
    cmd.op    = OP_NOP;
    cmd.addr  = idx[ADDR_W-1:0];
    cmd.step  = iter[STEP_W-1:0];
    cmd.first = (idx == '0);
    cmd.seed  = (count == '0);
    unique case (state)
      S_IDLE:     cmd.op = accept ? OP_LATCH : OP_NOP;
      S_APPEND: begin
        cmd.op   = OP_APPEND;
        cmd.addr = count[ADDR_W-1:0];
      end
      S_CL_DIFF:  cmd.op = OP_CL_DIFF;
      S_CL_MX:    cmd.op = OP_M_DXDX;
      S_CL_MY:    cmd.op = OP_M_DYDY;
      S_CL_CMP:   cmd.op = OP_CL_CMP;
      S_SG_RD2: begin
        cmd.op   = OP_SG_P1;
        cmd.addr = idx_p1[ADDR_W-1:0];
      end
      S_SG_P2:    cmd.op = OP_SG_P2;
      S_SG_MDX:   cmd.op = OP_M_DXDX;
      S_SG_MDY:   cmd.op = OP_M_DYDY;
      S_SG_MFXDX: cmd.op = OP_M_FXDX;
      S_SG_MFYDY: cmd.op = OP_M_FYDY;
      S_SG_MFXFX: cmd.op = OP_M_FXFX;
      S_SG_MFYFY: cmd.op = OP_M_FYFY;
      S_SG_CFIN:  cmd.op = OP_C_FIN;
      S_SG_WLH:   cmd.op = OP_WL_HH;
      S_SG_WSH:   cmd.op = OP_WSTEP;
      S_SG_WHH:   cmd.op = OP_W_HH;
      S_SG_WLA:   cmd.op = OP_WL_AC;
      S_SG_WSA:   cmd.op = OP_WSTEP;
      S_SG_DISC:  cmd.op = OP_DISC;
      S_SG_SQ:    cmd.op = OP_SQ_STEP;
      S_SG_NCALC: cmd.op = OP_NCALC;
      S_SG_NSEL:  cmd.op = OP_NSEL;
      S_SG_DIV:   cmd.op = OP_DIV_STEP;
      S_SG_MTX:   cmd.op = OP_M_TX;
      S_SG_MTY:   cmd.op = OP_M_TY;
      S_SG_HIT:   cmd.op = OP_HIT;
      default:    cmd.op = OP_NOP;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_APPEND: state_next = full ? S_OUT : S_APPEND;
            MODE_QUERY:  state_next = (count == '0) ? S_OUT : S_CL_RD;
            default:     state_next = S_OUT;
          endcase
        end
      end
      S_APPEND:   state_next = S_OUT;
      S_OUT:      state_next = out_load ? S_IDLE : S_OUT;
      S_CL_RD:    state_next = S_CL_DIFF;
      S_CL_DIFF:  state_next = S_CL_MX;
      S_CL_MX:    state_next = S_CL_MY;
      S_CL_MY:    state_next = S_CL_CMP;
      S_CL_CMP:   state_next = (idx_p1 < (CNT_W + 1)'(count)) ? S_CL_RD : S_CL_END;
      S_CL_END: begin
        if (stat.spd_zero || !(start_p1 < (CNT_W + 1)'(count))) begin
          state_next = S_OUT;
        end else begin
          state_next = S_SG_RD1;
        end
      end
      S_SG_RD1:   state_next = S_SG_RD2;
      S_SG_RD2:   state_next = S_SG_P2;
      S_SG_P2:    state_next = S_SG_MDX;
      S_SG_MDX:   state_next = S_SG_MDY;
      S_SG_MDY:   state_next = S_SG_MFXDX;
      S_SG_MFXDX: state_next = S_SG_MFYDY;
      S_SG_MFYDY: state_next = S_SG_MFXFX;
      S_SG_MFXFX: state_next = S_SG_MFYFY;
      S_SG_MFYFY: state_next = S_SG_CFIN;
      S_SG_CFIN:  state_next = stat.a_zero ? S_SG_NEXT : S_SG_WLH;
      S_SG_WLH:   state_next = S_SG_WSH;
      S_SG_WSH:   state_next = (iter == ITER_W'(WM_STEPS)) ? S_SG_WHH : S_SG_WSH;
      S_SG_WHH:   state_next = S_SG_WLA;
      S_SG_WLA:   state_next = S_SG_WSA;
      S_SG_WSA:   state_next = (iter == ITER_W'(WM_STEPS)) ? S_SG_DISC : S_SG_WSA;
      S_SG_DISC:  state_next = (!stat.c_neg && stat.ac_gt_hh) ? S_SG_NEXT : S_SG_SQ;
      S_SG_SQ:    state_next = (iter == ITER_W'(SQ_STEPS - 1)) ? S_SG_NCALC : S_SG_SQ;
      S_SG_NCALC: state_next = S_SG_NSEL;
      S_SG_NSEL:  state_next = (stat.ok1 || stat.ok2) ? S_SG_DIV : S_SG_NEXT;
      S_SG_DIV:   state_next = (iter == ITER_W'(DIV_STEPS - 1)) ? S_SG_MTX : S_SG_DIV;
      S_SG_MTX:   state_next = S_SG_MTY;
      S_SG_MTY:   state_next = S_SG_HIT;
      S_SG_HIT:   state_next = S_OUT;
      S_SG_NEXT:  state_next = (idx_p2 < (CNT_W + 1)'(count)) ? S_SG_RD1 : S_OUT;
      default:    state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      idx            <= '0;
      iter           <= '0;
      out_valid      <= 1'b0;
      res.status     <= ST_OK;
      res.query      <= 1'b0;
      res.found      <= 1'b0;
      res.best       <= '0;
      res.last_index <= '0;
    end else begin
      state <= state_next;

      // output beat handshake
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // iteration counter for multi-step units
      if (state_next != state) begin
        iter <= '0;
      end else begin
        iter <= iter + 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.status <= ST_OK;
            res.query  <= 1'b0;
            res.found  <= 1'b0;
            res.best   <= '0;
            idx        <= '0;
            if (in_mode == MODE_CLEAR) begin
              count <= '0;
            end else if (in_mode == MODE_APPEND && full) begin
              res.status <= ST_FULL;
            end else if (in_mode == MODE_QUERY && count == '0) begin
              res.status <= ST_EMPTY;
            end
          end
        end
        S_APPEND: begin
          if (count == '0) begin
            res.last_index <= '0;
          end
          count <= count + 1'b1;
        end
        S_CL_CMP: begin
          if (idx == '0 || stat.dd_less) begin
            res.best <= idx[ADDR_W-1:0];
          end
          idx <= idx_p1[CNT_W-1:0];
        end
        S_CL_END: begin
          res.query <= 1'b1;
          idx       <= CNT_W'(start);
        end
        S_SG_HIT: begin
          res.last_index <= idx[ADDR_W-1:0];
          res.found      <= 1'b1;
        end
        S_SG_NEXT: idx <= idx_p1[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pure_pursuit_lookahead_search_top.sv =====
// ----------------------------------------------------------------------------
// pure_pursuit_lookahead_search_top
// Waypoint path store with nearest-waypoint and lookahead-circle search.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command beat: tuser is the mode (clear, append,
//   query), tdata is x, y and speed. Every beat yields exactly one m_axis
//   result beat: tuser is the status, tdata the nearest waypoint and the
//   lookahead point. cfg_valid/cfg_data writes the lookahead radius; it is
//   always ready and should only be written while no command is in flight.
// Sequencing:
//   Clear, unused, rejected and empty-query beats go straight to the
//   output state; an append first passes through its write state.
//   A query scans the stored waypoints, then searches segments: it leaves
//   a zero-length one after its coefficients, a missed one after the wide
//   products, one with no root on it after the square root, and ends on a
//   hit after the divider. The nearest scan reads each waypoint from the
//   single-port path RAM and uses the shared 26x26 multiplier; a full
//   segment runs two four-part wide products, the bit-serial square root
//   and the Q16 divider. One command is in flight at a time; the next beat
//   is taken once the result sits in the output register.
// Reset clears the path and the lookahead point and sets the radius to 960.
// When the receiver stalls, the result is held and the block waits before
// loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module pure_pursuit_lookahead_search_top
  import pplook_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, speed
  input  logic [MODE_W-1:0]      s_axis_tuser,  // mode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // closest_index, closest_speed, at_end, lookahead_x, lookahead_y,
  // lookahead_index, intersect_found
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [STAT_W-1:0]      m_axis_tuser,  // status
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [DIST_W-1:0]      cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  ctl_res_t res;
  logic out_load;
  logic signed [COORD_W-1:0] last_x, last_y;
  logic signed [SPD_W-1:0] best_spd;

  assign cfg_ready = 1'b1;

  pplook_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_load  (out_load),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res)
  );

  pplook_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_x     ($signed(s_axis_tdata[COORD_W-1:0])),
    .in_y     ($signed(s_axis_tdata[2*COORD_W-1:COORD_W])),
    .in_spd   ($signed(s_axis_tdata[WP_W-1:2*COORD_W])),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .last_x   (last_x),
    .last_y   (last_y),
    .best_spd (best_spd)
  );

  // result register
  logic [INDEX_W-1:0] o_cidx;
  logic [SPD_W-1:0] o_cspd;
  logic o_at_end;

  assign o_cidx   = res.query ? INDEX_W'(res.best) : '0;
  assign o_cspd   = res.query ? best_spd : '0;
  assign o_at_end = res.query && stat.spd_zero;

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= res.status;
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, res.found, INDEX_W'(res.last_index),
                       last_y, last_x, o_at_end, o_cspd, o_cidx};
    end
  end

  // a pending result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending beat");

  // one command in flight: ready drops after an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command taken while busy");

  // a query on an empty path never reports a new intersection
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> !m_axis_tdata[OUT_FIELD_W-1])
    else $error("intersection flagged on empty path");

endmodule

`default_nettype wire

// ===== tb/sv/pplook_checker.sv =====
// ----------------------------------------------------------------------------
// pplook_checker
// Watches the command, result and radius channels of the lookahead search
// block. It keeps its own copy of the path and the lookahead point, works out
// the result of every accepted command and compares each result beat with
// the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pplook_checker
  import pplook_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, speed
  input  logic [MODE_W-1:0]      s_axis_tuser,  // mode
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // closest_index, closest_speed, at_end, lookahead_x, lookahead_y,
  // lookahead_index, intersect_found
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [STAT_W-1:0]      m_axis_tuser,  // status
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [DIST_W-1:0]      cfg_data,
  output int                     errors,
  output int                     pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [INDEX_W-1:0]        near_idx;
    logic signed [SPD_W-1:0]   near_spd;
    logic                      at_end;
    logic signed [COORD_W-1:0] la_x;
    logic signed [COORD_W-1:0] la_y;
    logic [INDEX_W-1:0]        la_idx;
    logic                      found;
  } path_result_t;

  // path model
  logic signed [COORD_W-1:0] wp_x [PATH_DEPTH];
  logic signed [COORD_W-1:0] wp_y [PATH_DEPTH];
  logic signed [SPD_W-1:0]   wp_spd [PATH_DEPTH];
  int                        wp_count;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  int                        cur_idx;
  logic [DIST_W-1:0]         radius;

  path_result_t result_q[$];

  // q16 crossing point along segment i, or -1 when the circle misses it
  function automatic longint segment_cross(int i, wide_t rx, wide_t ry);
    wide_t x1, y1, x2, y2, dx, dy, fx, fy, a, h, c, disc, root, cand, n;
    x1 = wp_x[i];
    y1 = wp_y[i];
    x2 = wp_x[i+1];
    y2 = wp_y[i+1];
    dx = x2 - x1;
    dy = y2 - y1;
    fx = x1 - rx;
    fy = y1 - ry;
    a = dx * dx + dy * dy;
    h = fx * dx + fy * dy;
    c = fx * fx + fy * fy - wide_t'(radius) * wide_t'(radius);
    if (a == 0) return -1;
    disc = h * h - a * c;
    if (disc < 0) return -1;
    root = 0;
    for (int b = 52; b >= 0; b--) begin
      cand = root | (wide_t'(1) <<< b);
      if (cand * cand <= disc) root = cand;
    end
    // far root first, then the near one
    n = -h + root;
    if (!(n >= 0 && n <= a)) n = -h - root;
    if (!(n >= 0 && n <= a)) return -1;
    if (n >= a) return 65536;
    return longint'((n <<< 16) / a);
  endfunction

  task automatic predict_command(logic [MODE_W-1:0] mode, logic signed [COORD_W-1:0] px,
                                 logic signed [COORD_W-1:0] py,
                                 logic signed [SPD_W-1:0] spd);
    path_result_t r;
    longint bd, dd, ddx, ddy, t;
    int best, first;
    wide_t x1, y1, ex, ey;
    r = '{default: '0};
    r.status = ST_OK;
    if (mode == MODE_CLEAR) begin
      wp_count = 0;
    end else if (mode == MODE_APPEND) begin
      if (wp_count >= PATH_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        wp_x[wp_count] = px;
        wp_y[wp_count] = py;
        wp_spd[wp_count] = spd;
        // first waypoint seeds the lookahead point
        if (wp_count == 0) begin
          cur_x = px;
          cur_y = py;
          cur_idx = 0;
        end
        wp_count++;
      end
    end else if (mode == MODE_QUERY) begin
      if (wp_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // nearest waypoint, first one wins ties
        best = 0;
        for (int i = 0; i < wp_count; i++) begin
          ddx = longint'(px) - longint'(wp_x[i]);
          ddy = longint'(py) - longint'(wp_y[i]);
          dd = ddx * ddx + ddy * ddy;
          if (i == 0 || dd < bd) begin
            bd = dd;
            best = i;
          end
        end
        r.near_idx = best[INDEX_W-1:0];
        r.near_spd = wp_spd[best];
        r.at_end = (wp_spd[best] == 0);
        if (!r.at_end) begin
          first = (best > cur_idx) ? best : cur_idx;
          for (int i = first; i + 1 < wp_count; i++) begin
            t = segment_cross(i, wide_t'(px), wide_t'(py));
            if (t >= 0) begin
              x1 = wp_x[i];
              y1 = wp_y[i];
              ex = x1 + (((wide_t'(wp_x[i+1]) - x1) * t + 32768) >>> 16);
              ey = y1 + (((wide_t'(wp_y[i+1]) - y1) * t + 32768) >>> 16);
              cur_x = ex[COORD_W-1:0];
              cur_y = ey[COORD_W-1:0];
              cur_idx = i;
              r.found = 1'b1;
              break;
            end
          end
        end
      end
    end
    r.la_x = cur_x;
    r.la_y = cur_y;
    r.la_idx = cur_idx[INDEX_W-1:0];
    result_q = {result_q, r};
  endtask

  task automatic compare_result();
    path_result_t e, g;
    g.status   = m_axis_tuser;
    g.near_idx = m_axis_tdata[7:0];
    g.near_spd = m_axis_tdata[23:8];
    g.at_end   = m_axis_tdata[24];
    g.la_x     = m_axis_tdata[48:25];
    g.la_y     = m_axis_tdata[72:49];
    g.la_idx   = m_axis_tdata[80:73];
    g.found    = m_axis_tdata[81];
    if (result_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("checker: result beat with nothing expected: %p", g);
      return;
    end
    e = result_q.pop_front();
    if (g != e) begin
      errors++;
      if (errors <= 10) $display("checker: mismatch\n  expected %p\n  actual   %p", e, g);
    end
  endtask

  // model update on every accepted beat, radius write and result beat
  always @(posedge clk) begin
    if (rst) begin
      wp_count = 0;
      cur_x = '0;
      cur_y = '0;
      cur_idx = 0;
      radius = DIST_W'(LA_RESET);
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) radius = cfg_data;
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready)
        predict_command(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[47:24],
                        s_axis_tdata[63:48]);
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the lookahead search block: directed corner cases, a full
// path, then random paths with queries around them under several radii,
// with random idling on both sides. The checker gives the verdict data.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pplook_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int ITEMS = 290;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DIST_W-1:0]      cfg_data = '0;
  int                     errors, pending;
  int                     sent = 0;
  int                     cycles = 0;
  bit                     quiet = 1'b0;
  bit                     hold_req = 1'b0;

  pure_pursuit_lookahead_search_top uut (.*);

  pplook_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    repeat (12) @(posedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one command beat; tvalid stays high on return
  task automatic send_cmd(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] px,
                          logic [COORD_W-1:0] py, logic [SPD_W-1:0] spd, bit gaps = 1'b1);
    if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {spd, py, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_radius(logic [DIST_W-1:0] r);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SPD_W-1:0] pick_speed();
    return ($urandom_range(0, 4) == 0) ? SPD_W'(0) : SPD_W'($urandom_range(1, 65535));
  endfunction

  // random path near a base point, then queries around it
  task automatic path_round(int npts, int step, int nq);
    int bx, by, x, y, k;
    bx = $signed($urandom_range(0, 2097152)) - 1048576;
    by = $signed($urandom_range(0, 2097152)) - 1048576;
    send_cmd(MODE_CLEAR, '0, '0, '0);
    x = bx;
    y = by;
    for (int i = 0; i < npts; i++) begin
      send_cmd(MODE_APPEND, COORD_W'(x), COORD_W'(y),
               (i == npts - 1 && $urandom_range(0, 1)) ? SPD_W'(0) : pick_speed());
      if ($urandom_range(0, 9) != 0) begin
        x += $signed($urandom_range(0, 2 * step)) - step;
        y += $signed($urandom_range(0, 2 * step)) - step;
      end
    end
    for (int q = 0; q < nq; q++) begin
      k = $urandom_range(0, 2 * step);
      send_cmd(MODE_QUERY, COORD_W'(bx + $signed($urandom_range(0, 2 * k)) - k),
               COORD_W'(by + $signed($urandom_range(0, 2 * k)) - k), SPD_W'($urandom()));
      bx += $signed($urandom_range(0, step)) - step / 4;
      by += $signed($urandom_range(0, step)) - step / 4;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // directed: empty query, unused mode, extremes, zero-length segment
    send_cmd(MODE_QUERY, 24'h123456, 24'h654321, '0);
    send_cmd(MODE_NONE, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_cmd(MODE_APPEND, 24'h800000, 24'h800000, 16'h0100);
    send_cmd(MODE_APPEND, 24'h7FFFFF, 24'h7FFFFF, 16'h8000);
    send_cmd(MODE_APPEND, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);
    send_cmd(MODE_APPEND, '0, '0, '0);
    send_cmd(MODE_QUERY, 24'h800000, 24'h800000, '0);
    send_cmd(MODE_QUERY, 24'h7FFFFF, 24'h800000, '0);
    send_cmd(MODE_QUERY, '0, '0, '0);
    send_cmd(MODE_QUERY, 24'h000100, 24'hFFFF00, '0);
    send_cmd(MODE_CLEAR, '0, '0, '0);
    send_cmd(MODE_APPEND, '0, '0, 16'h0100);
    send_cmd(MODE_APPEND, 24'd2000, '0, 16'h0100);
    send_cmd(MODE_APPEND, 24'd2000, 24'd2000, 16'h0100);
    send_cmd(MODE_APPEND, 24'd2000, 24'd4000, '0);
    send_cmd(MODE_QUERY, '0, '0, '0);
    send_cmd(MODE_QUERY, 24'd1000, 24'd100, '0);
    send_cmd(MODE_QUERY, 24'd1900, 24'd2500, '0);
    send_cmd(MODE_QUERY, 24'd2000, 24'd4000, '0);
    send_cmd(MODE_QUERY, 24'd900000, 24'd900000, '0);

    // full path, rejected append, one long query
    set_radius(DIST_W'(20'hFFFFF));
    send_cmd(MODE_CLEAR, '0, '0, '0);
    for (int i = 0; i < PATH_DEPTH; i++)
      send_cmd(MODE_APPEND, COORD_W'(i * 300), COORD_W'((i % 7) * 50), 16'h0080, 1'b0);
    send_cmd(MODE_APPEND, 24'd5, 24'd5, 16'h0100);
    send_cmd(MODE_QUERY, 24'd100, 24'd10, '0);

    // result path held off while commands keep coming
    set_radius(DIST_W'(0));
    hold_req = 1'b1;
    path_round(4, 500, 3);
    // sender waits for every result
    drain();

    // random rounds under several radii
    do begin
      case ($urandom_range(0, 4))
        0: set_radius(DIST_W'($urandom_range(0, 1048575)));
        1: set_radius(DIST_W'($urandom_range(200, 3000)));
        default: ;
      endcase
      if ($urandom_range(0, 5) == 0) begin
        // noise over the full field ranges
        repeat (4)
          send_cmd(MODE_W'($urandom_range(0, 3)), COORD_W'($urandom()),
                   COORD_W'($urandom()), SPD_W'($urandom()));
      end else begin
        path_round($urandom_range(2, 10), $urandom_range(100, 3000),
                   $urandom_range(2, 8));
      end
    end while (sent < ITEMS - 12);

    // last stretch with no idling
    set_radius(DIST_W'(LA_RESET));
    quiet = 1'b1;
    path_round(4, 1500, 4);
    drain();
    repeat (50) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pplook_pkg.sv
rtl/pplook_ram.sv
rtl/pplook_dp.sv
rtl/pplook_ctrl.sv
rtl/pure_pursuit_lookahead_search_top.sv
tb/sv/pplook_checker.sv
tb/sv/tb.sv
